@@ src/binary_arithmetic_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary arithmetic encoder
// Same-cycle and next-cycle implication checks on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_ARITHMETIC_ENCODER_DEFINES_SVH
`define BINARY_ARITHMETIC_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bae assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BAE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bae assertion failed");

`endif

@@ src/bae_pkg.sv @@
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants of the binary arithmetic encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bae_pkg;

    localparam int PROB_BITS_DEF = 15;
    localparam int PROB_IN_W     = 15;
    localparam int RANGE_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 3;
    localparam int Q_DEPTH_DEF   = 2;

    localparam logic [BYTE_W-1:0]  FILL_BYTE = 8'hFF;
    localparam logic [RANGE_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]   BYTES_PER_WORD = 3'd4;
    localparam logic [CNT_W-1:0]   LAST_BYTE_LEFT = 3'd1;

    // One queued burst: bytes taken from the top of word, count of them.
    typedef struct packed {
        logic [RANGE_W-1:0] word;
        logic [CNT_W-1:0]   count;
    } t_entry;

    typedef enum logic {
        FS_IDLE,
        FS_UPDATE
    } t_front_state;

endpackage

@@ src/bae_front.sv @@
// ----------------------------------------------------------------------------
// bae_front
// Accepts items, forms the split point, updates the range on encode items and
// pushes the emitted bytes of each item into the queue as one burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bae_front
    import bae_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic                 i_bit,
    input  logic [PROB_IN_W-1:0] i_prob,
    output logic                 o_push_valid,
    output t_entry               o_push_entry,
    input  logic                 i_push_ready
);

    localparam int PW    = (PROB_BITS > PROB_IN_W) ? PROB_BITS : PROB_IN_W;
    localparam int PRODW = RANGE_W + PW;
    localparam logic [PW-1:0] PMAX = PW'((1 << PROB_BITS) - 1);

    t_front_state r_state, n_state;

    logic [RANGE_W-1:0] r_low, r_high;
    logic [RANGE_W-1:0] n_low, n_high;
    logic [PRODW-1:0]   r_prod;
    logic               r_op, r_bit;

    logic [PW-1:0]      p_ext, p_sat;
    logic [RANGE_W-1:0] span;
    logic [PRODW-1:0]   scaled;
    logic [RANGE_W-1:0] mid, up_low, up_high, diff;
    logic [CNT_W-1:0]   nbytes;
    logic               accept, done;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == FS_IDLE);

    assign p_ext = PW'(i_prob);
    assign p_sat = (p_ext > PMAX) ? PMAX : p_ext;
    assign span  = r_high - r_low;

    // Multiply on accept; the update finishes in FS_UPDATE once its burst is pushed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= PRODW'(span) * PRODW'(p_sat);
            r_op   <= i_op;
            r_bit  <= i_bit;
        end
    end

    assign scaled  = r_prod >> PROB_BITS;
    assign mid     = r_low + scaled[RANGE_W-1:0];
    assign up_high = r_bit ? mid : r_high;
    assign up_low  = r_bit ? r_low : mid + RANGE_W'(1);
    assign diff    = up_high ^ up_low;

    // Count leading byte positions where low and high agree.
    always_comb begin
        if (diff[31:24] != 8'h00) begin
            nbytes = 3'd0;
        end else if (diff[23:16] != 8'h00) begin
            nbytes = 3'd1;
        end else if (diff[15:8] != 8'h00) begin
            nbytes = 3'd2;
        end else if (diff[7:0] != 8'h00) begin
            nbytes = 3'd3;
        end else begin
            nbytes = 3'd4;
        end
    end

    always_comb begin
        case (nbytes)
            3'd0: begin
                n_high = up_high;
                n_low  = up_low;
            end
            3'd1: begin
                n_high = {up_high[23:0], FILL_BYTE};
                n_low  = {up_low[23:0], 8'h00};
            end
            3'd2: begin
                n_high = {up_high[15:0], {2{FILL_BYTE}}};
                n_low  = {up_low[15:0], 16'h0000};
            end
            3'd3: begin
                n_high = {up_high[7:0], {3{FILL_BYTE}}};
                n_low  = {up_low[7:0], 24'h000000};
            end
            default: begin
                n_high = ALL_ONES;
                n_low  = '0;
            end
        endcase
    end

    // Flush sends the whole of high and leaves the range alone.
    always_comb begin
        o_push_valid       = 1'b0;
        o_push_entry.word  = r_op ? r_high : up_high;
        o_push_entry.count = r_op ? BYTES_PER_WORD : nbytes;
        if (r_state == FS_UPDATE) begin
            o_push_valid = r_op || (nbytes != 3'd0);
        end
    end

    assign done = (r_state == FS_UPDATE) && (!o_push_valid || i_push_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (accept) n_state = FS_UPDATE;
            end
            FS_UPDATE: begin
                if (done) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= ALL_ONES;
        end else if (done && !r_op) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule

@@ src/bae_queue.sv @@
// ----------------------------------------------------------------------------
// bae_queue
// Short first-in first-out queue of byte bursts between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bae_queue
    import bae_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_entry,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ src/bae_back.sv @@
// ----------------------------------------------------------------------------
// bae_back
// Takes bursts from the queue and sends their bytes one per transfer,
// most significant first, marking the last byte of each burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bae_back
    import bae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  t_entry            i_pop_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last
);

    logic [RANGE_W-1:0] r_word;
    logic [CNT_W-1:0]   r_left;
    logic               r_busy;
    logic               xfer, finish;

    assign o_valid = r_busy;
    assign o_byte  = r_word[RANGE_W-1 -: BYTE_W];
    assign o_last  = (r_left == LAST_BYTE_LEFT);
    assign xfer    = r_busy && i_ready;
    assign finish  = xfer && o_last;
    assign o_pop   = i_pop_valid && (!r_busy || finish);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_pop_entry.word;
        end else if (xfer) begin
            r_word <= {r_word[RANGE_W-BYTE_W-1:0], BYTE_W'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_left <= i_pop_entry.count;
        end else if (xfer) begin
            // drop out of busy once the last byte is taken
            r_busy <= !o_last;
            r_left <= r_left - CNT_W'(1);
        end
    end

endmodule

@@ src/binary_arithmetic_encoder.sv @@
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Path: an item is registered as product and state in the front, as a burst
// in the queue, then as the back's word, whose busy flag makes its byte valid.
// Throughput: a new item waits for the multiply then update loop on the range
// registers and push of the last; one byte per cycle while receiver is ready.
// Reset: range low 0, range high all ones, queue and output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "binary_arithmetic_encoder_defines.svh"

module binary_arithmetic_encoder
    import bae_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF,
    parameter int Q_DEPTH   = Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] bit_req, [15:1] prob_one
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last_of_run
);

    logic   push_valid, push_ready, pop_valid, pop;
    t_entry push_entry, pop_entry;

    bae_front #(
        .PROB_BITS(PROB_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_bit        (s_axis_tdata[0]),
        .i_prob       (s_axis_tdata[15:1]),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    bae_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop        (pop)
    );

    bae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    `BAE_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BAE_ASSERT_NXT(a_push_held, push_valid && !push_ready, push_valid && $stable(push_entry))
    `BAE_ASSERT_IMP(a_push_count, push_valid, push_entry.count != '0 && push_entry.count <= BYTES_PER_WORD)
    `BAE_ASSERT_IMP(a_pop_needs_data, pop, pop_valid)

endmodule

@@ tb/sv/binary_arithmetic_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_tb
// Streams encode and flush items into the encoder and checks every code
// byte and its run marker against a range-register model kept in step with
// each accepted input transfer. Three phases vary the idle rates on both
// sides; one long receiver hold-off backs the encoder up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_arithmetic_encoder_tb;
    import bae_pkg::*;

    typedef struct packed {
        logic                 flush;
        logic                 bit_val;
        logic [PROB_IN_W-1:0] prob;
    } t_coder_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_code_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // [0] bit_req, [15:1] prob_one
    logic               s_axis_tuser = 1'b0; // [0] op
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;        // [7:0] out_byte
    logic               m_axis_tlast;        // last_of_run

    t_coder_item        pending_items[$];
    t_code_byte         code_bytes_q[$];
    logic [RANGE_W-1:0] model_low  = '0;
    logic [RANGE_W-1:0] model_high = ALL_ONES;
    bit                 in_taken = 1'b0;
    bit                 rx_hold = 1'b0;
    int                 tx_idle_pct = 33;
    int                 rx_idle_pct = 87;
    int                 phase = 0;
    int                 err_count = 0;

    binary_arithmetic_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string what, input int exp_v, input int got_v);
        if (err_count < 100) begin
            $display("ERROR at %0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
        end
        err_count++;
    endtask

    // Narrow the range for one item and queue the bytes it pushes out.
    task automatic code_item(input t_coder_item it);
        logic [RANGE_W-1:0] span;
        logic [RANGE_W-1:0] mid;
        logic [63:0]        prod;
        logic [PROB_IN_W-1:0] p;
        int                 n;
        t_code_byte         cb;
        if (it.flush) begin
            for (n = 0; n < 4; n++) begin
                cb.data = model_high[RANGE_W-1-8*n -: BYTE_W];
                cb.last = (n == 3);
                code_bytes_q.push_back(cb);
            end
        end else begin
            p = it.prob;
            if (int'(p) > (1 << PROB_BITS_DEF) - 1) begin
                p = PROB_IN_W'((1 << PROB_BITS_DEF) - 1);
            end
            span = model_high - model_low;
            prod = 64'(span) * 64'(p);
            mid  = model_low + RANGE_W'(prod >> PROB_BITS_DEF);
            if (it.bit_val) begin
                model_high = mid;
            end else begin
                model_low = mid + RANGE_W'(1);
            end
            n = 0;
            while (n < 4 && (model_high ^ model_low) < 32'h0100_0000) begin
                cb.data = model_high[RANGE_W-1 -: BYTE_W];
                cb.last = 1'b0;
                code_bytes_q.push_back(cb);
                model_high = {model_high[RANGE_W-BYTE_W-1:0], FILL_BYTE};
                model_low  = {model_low[RANGE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                n++;
            end
            if (n > 0) begin
                code_bytes_q[code_bytes_q.size()-1].last = 1'b1;
            end
        end
    endtask

    task automatic push_item(input logic flush, input logic bit_val, input int prob);
        t_coder_item it;
        it.flush   = flush;
        it.bit_val = bit_val;
        it.prob    = PROB_IN_W'(prob);
        pending_items.push_back(it);
    endtask

    // Wait until every queued item went in and every byte came out.
    task automatic drain();
        while (pending_items.size() != 0 || code_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    // Input driver: hold an offered item until its transfer, else maybe idle.
    always @(negedge i_clk) begin : drive_in
        bit          was_taken;
        bit          go;
        t_coder_item it;
        was_taken = in_taken;
        if (in_taken) begin
            void'(pending_items.pop_front());
            in_taken = 1'b0;
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || was_taken) begin
            go = pending_items.size() != 0 && ($urandom_range(99) >= tx_idle_pct);
            s_axis_tvalid <= go;
            if (go) begin
                it = pending_items[0];
                s_axis_tdata <= {it.prob, it.bit_val};
                s_axis_tuser <= it.flush;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin : watch
        t_coder_item it;
        t_code_byte  cb;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                it.flush   = s_axis_tuser;
                it.bit_val = s_axis_tdata[0];
                it.prob    = s_axis_tdata[15:1];
                code_item(it);
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (code_bytes_q.size() == 0) begin
                    flag_error("unexpected byte", 0, int'(m_axis_tdata));
                end else begin
                    cb = code_bytes_q.pop_front();
                    if (m_axis_tdata !== cb.data) begin
                        flag_error("out_byte", int'(cb.data), int'(m_axis_tdata));
                    end
                    if (m_axis_tlast !== cb.last) begin
                        flag_error("last_of_run", int'(cb.last), int'(m_axis_tlast));
                    end
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps streaming.
    initial begin
        wait (phase == 2);
        repeat (30) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (250) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int  r;
        int  sel;
        int  p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: flush from reset, collapsing probabilities, ignored fields.
        push_item(1'b1, 1'b0, 0);
        push_item(1'b0, 1'b1, 0);
        push_item(1'b0, 1'b0, 0);
        push_item(1'b0, 1'b0, 32767);
        push_item(1'b0, 1'b1, 32767);
        push_item(1'b0, 1'b1, 16384);
        push_item(1'b0, 1'b0, 16384);
        push_item(1'b0, 1'b1, 1);
        push_item(1'b0, 1'b0, 1);
        push_item(1'b0, 1'b0, 32766);
        push_item(1'b1, 1'b1, 32767);
        push_item(1'b0, 1'b1, 21845);
        push_item(1'b0, 1'b0, 10922);
        push_item(1'b0, 1'b1, 0);
        push_item(1'b0, 1'b1, 0);
        push_item(1'b0, 1'b0, 32767);
        push_item(1'b0, 1'b0, 32767);
        push_item(1'b0, 1'b1, 5);
        push_item(1'b1, 1'b0, 12345);
        push_item(1'b0, 1'b0, 32767);

        for (int ph = 0; ph < 3; ph++) begin
            phase       = ph;
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 87 : 0;
            rx_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 33 : 0;
            for (int k = 0; k < 155; k++) begin
                r   = $urandom_range(99);
                sel = $urandom_range(9);
                case (sel)
                    0:       p = 0;
                    1:       p = 32767;
                    2:       p = $urandom_range(15);
                    3:       p = 32767 - $urandom_range(15);
                    default: p = $urandom_range(32767);
                endcase
                push_item(r < 4, 1'($urandom_range(1)), p);
            end
            // Sender pauses here until every byte has come out.
            drain();
        end

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
